### hdl/flc_pkg.sv
// flc_pkg: shared types for the fifo replacement lookup cache
// holds the control word that travels down the chain of slot cells
// no dependencies
package flc_pkg;

   // control word carried alongside each request through the slot chain
   typedef struct packed {
      logic valid;   // stage holds a live request
      logic fill;    // request is a fill, else a lookup
      logic hit;     // some slot matched the lookup key so far
      logic evicted; // fill landed on a slot that was valid
   } flc_ctl_type;

endpackage : flc_pkg

### hdl/flc_cell.sv
// flc_cell: one cache slot (valid, key, record) plus one pipeline stage
// compares the passing request against its slot and updates it on fills
// depends on flc_pkg
module flc_cell #(
   parameter int SLOT_INDEX = 0,
   parameter int PTR_BITS   = 9,
   parameter int KEY_BITS   = 44,
   parameter int DATA_BITS  = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  flc_pkg::flc_ctl_type     ctl_i,
   input  logic [PTR_BITS-1:0]      ptr_i,
   input  logic [KEY_BITS-1:0]      key_i,
   input  logic [DATA_BITS-1:0]     data_i,
   output flc_pkg::flc_ctl_type     ctl_o,
   output logic [PTR_BITS-1:0]      ptr_o,
   output logic [KEY_BITS-1:0]      key_o,
   output logic [DATA_BITS-1:0]     data_o
);
   import flc_pkg::*;

   // slot contents
   logic                 slot_valid_ff, slot_valid_in;
   logic [KEY_BITS-1:0]  slot_key_ff, slot_key_in;
   logic [DATA_BITS-1:0] slot_rec_ff, slot_rec_in;

   // stage registers toward the next cell
   flc_ctl_type          ctl_ff, ctl_in;
   logic [PTR_BITS-1:0]  ptr_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [DATA_BITS-1:0] data_ff, data_in;

   logic match;
   logic is_target;
   logic lookup_hit;

   // key compare and slot selection for fills
   assign match      = slot_valid_ff && (slot_key_ff == key_i);
   assign is_target  = ctl_i.valid && ctl_i.fill && (ptr_i == PTR_BITS'(SLOT_INDEX));
   assign lookup_hit = ctl_i.valid && !ctl_i.fill && match;

   // next values for the slot and the stage
   always_comb begin
      slot_valid_in = slot_valid_ff;
      slot_key_in   = slot_key_ff;
      slot_rec_in   = slot_rec_ff;
      if (is_target) begin
         slot_valid_in = 1'b1;
         slot_key_in   = key_i;
         slot_rec_in   = data_i;
      end else if (ctl_i.valid && ctl_i.fill && match) begin
         // keep keys unique: newest fill wins, no eviction flag
         slot_valid_in = 1'b0;
      end

      ctl_in         = ctl_i;
      ctl_in.hit     = ctl_i.hit | lookup_hit;
      ctl_in.evicted = ctl_i.evicted | (is_target && slot_valid_ff);
      data_in        = lookup_hit ? slot_rec_ff : data_i;
   end

   // valid bit and stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         ctl_ff        <= '0;
      end else if (advance) begin
         slot_valid_ff <= slot_valid_in;
         ctl_ff        <= ctl_in;
      end
   end

   // slot payload and stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         slot_key_ff <= slot_key_in;
         slot_rec_ff <= slot_rec_in;
         ptr_ff      <= ptr_i;
         key_ff      <= key_i;
         data_ff     <= data_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign ptr_o  = ptr_ff;
   assign key_o  = key_ff;
   assign data_o = data_ff;

endmodule : flc_cell

### hdl/fifo_replacement_lookup_cache_unit.sv
// fifo_replacement_lookup_cache_unit: fully associative cache, fifo replacement
// a request word passes down the chain of slot cells, each a pipeline stage, and leaves as the response word
// throughput: one word per cycle; the whole cell chain stalls while the response waits
// reset clears all slot valid bits and the write pointer directly, with no clearing pass
// depends on flc_pkg and flc_cell
module fifo_replacement_lookup_cache_unit #(
   parameter int DEPTH     = 512,
   parameter int KEY_BITS  = 44,
   parameter int DATA_BITS = 64,
   localparam int REQ_BITS = ((KEY_BITS + DATA_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = ((DATA_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,  // key, record, zero pad
   input  logic [0:0]          req_tuser,  // op (0 lookup, 1 fill)
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,  // data, zero pad
   output logic [1:0]          rsp_tuser   // hit, evicted
);
   import flc_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                advance;
   logic                fill_accept;
   logic [PTR_BITS-1:0] wptr_ff, wptr_in;

   flc_ctl_type          ctl_chain  [DEPTH+1];
   logic [PTR_BITS-1:0]  ptr_chain  [DEPTH+1];
   logic [KEY_BITS-1:0]  key_chain  [DEPTH+1];
   logic [DATA_BITS-1:0] data_chain [DEPTH+1];

   flc_ctl_type          ctl_last;
   logic [DATA_BITS-1:0] rsp_data;

   // chain moves whenever the last stage is empty or being drained
   assign advance     = !ctl_last.valid || rsp_tready;
   assign req_tready  = advance && !reset;
   assign fill_accept = req_tvalid && req_tready && req_tuser[0];

   // ring write pointer
   always_comb begin
      wptr_in = wptr_ff;
      if (fill_accept) begin
         if (wptr_ff == PTR_BITS'(DEPTH - 1)) begin
            wptr_in = '0;
         end else begin
            wptr_in = wptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
      end
   end

   // request word enters the chain
   assign ctl_chain[0]  = {req_tvalid, req_tuser[0], 1'b0, 1'b0};
   assign ptr_chain[0]  = wptr_ff;
   assign key_chain[0]  = req_tdata[KEY_BITS-1:0];
   assign data_chain[0] = req_tuser[0] ? req_tdata[KEY_BITS+DATA_BITS-1:KEY_BITS] : '0;

   // row of slot cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_slot
      flc_cell #(
         .SLOT_INDEX (g),
         .PTR_BITS   (PTR_BITS),
         .KEY_BITS   (KEY_BITS),
         .DATA_BITS  (DATA_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctl_i   (ctl_chain[g]),
         .ptr_i   (ptr_chain[g]),
         .key_i   (key_chain[g]),
         .data_i  (data_chain[g]),
         .ctl_o   (ctl_chain[g+1]),
         .ptr_o   (ptr_chain[g+1]),
         .key_o   (key_chain[g+1]),
         .data_o  (data_chain[g+1])
      );
   end

   // response word from the last cell
   assign ctl_last   = ctl_chain[DEPTH];
   assign rsp_data   = ctl_last.fill ? '0 : data_chain[DEPTH];
   assign rsp_tvalid = ctl_last.valid;
   assign rsp_tdata  = RSP_BITS'(rsp_data);
   assign rsp_tuser  = {ctl_last.evicted, ctl_last.hit};

endmodule : fifo_replacement_lookup_cache_unit

### sim/tb_fifo_replacement_lookup_cache_unit.sv
// tb_fifo_replacement_lookup_cache_unit: self-checking bench for the fifo replacement lookup cache
// a directed table, then random lookup and fill traffic; every response is checked against the
// table's expected result or a cycle-free model of the cache kept here; needs only the cache rtl
`timescale 1ns / 1ps

module tb_fifo_replacement_lookup_cache_unit;

   localparam int DEPTH       = 512;
   localparam int KEY_BITS    = 44;
   localparam int DATA_BITS   = 64;
   localparam int REQ_BITS    = 112;
   localparam int RSP_BITS    = 64;
   localparam int RANDOM_WORDS = 1250;
   localparam int KEY_POOL    = 600;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DIRECTED_ROWS = 20;

   typedef enum logic {OP_LOOKUP = 1'b0, OP_FILL = 1'b1} cache_op_type;

   typedef struct packed {
      logic                 hit;
      logic [DATA_BITS-1:0] data;
      logic                 evicted;
   } cache_result_type;

   typedef struct packed {
      cache_op_type         op;
      logic [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0] rec;
      logic                 typed;
      cache_result_type     want;
   } directed_row_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata  = '0;  // key, record, zero pad
   logic [0:0]          req_tuser  = '0;  // op (0 lookup, 1 fill)
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;        // data, zero pad
   logic [1:0]          rsp_tuser;        // hit, evicted

   // model of the cache contents
   logic [KEY_BITS-1:0]  model_key   [DEPTH];
   logic [DATA_BITS-1:0] model_rec   [DEPTH];
   logic                 model_valid [DEPTH];
   int                   model_ptr;

   cache_result_type     results_due [$];
   logic [KEY_BITS-1:0]  key_pool [KEY_POOL];
   int                   error_count = 0;
   int                   cycle_count = 0;
   int                   words_sent  = 0;
   logic                 quiet       = 1'b0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_LOOKUP, 44'h0,             64'h0,                  1'b1, '{1'b0, 64'h0, 1'b0}},
      '{OP_LOOKUP, 44'hFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'h0, 1'b0}},
      '{OP_FILL,   44'hFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'h0, 1'b0}},
      '{OP_LOOKUP, 44'hFFF_FFFF_FFFF, 64'h0,
        1'b1, '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0}},
      '{OP_FILL,   44'h0,             64'h0,                  1'b1, '{1'b0, 64'h0, 1'b0}},
      '{OP_LOOKUP, 44'h0,             64'h0,                  1'b1, '{1'b1, 64'h0, 1'b0}},
      // same key again: older copy is dropped silently
      '{OP_FILL,   44'h0,             64'h5555_5555_5555_5555, 1'b1, '{1'b0, 64'h0, 1'b0}},
      '{OP_LOOKUP, 44'h0,             64'h0,
        1'b1, '{1'b1, 64'h5555_5555_5555_5555, 1'b0}},
      '{OP_FILL,   44'hAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{1'b0, 64'h0, 1'b0}},
      '{OP_LOOKUP, 44'h555_5555_5555, 64'h0,                  1'b1, '{1'b0, 64'h0, 1'b0}},
      '{OP_LOOKUP, 44'hAAA_AAAA_AAAA, 64'h0,
        1'b1, '{1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0}},
      '{OP_FILL,   44'hFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF, 1'b1, '{1'b0, 64'h0, 1'b0}},
      '{OP_LOOKUP, 44'hFFF_FFFF_FFFF, 64'h0,
        1'b1, '{1'b1, 64'h0123_4567_89AB_CDEF, 1'b0}},
      // record field on a lookup is ignored
      '{OP_LOOKUP, 44'h0,             64'hFFFF_FFFF_FFFF_FFFF,
        1'b1, '{1'b1, 64'h5555_5555_5555_5555, 1'b0}},
      '{OP_FILL,   44'd9780306406157, 64'h8000_0000_0000_0001, 1'b1, '{1'b0, 64'h0, 1'b0}},
      '{OP_LOOKUP, 44'd9780306406157, 64'h0,
        1'b1, '{1'b1, 64'h8000_0000_0000_0001, 1'b0}},
      '{OP_LOOKUP, 44'd9780306406158, 64'h0,                  1'b1, '{1'b0, 64'h0, 1'b0}},
      '{OP_FILL,   44'h123_4567_89AB, 64'hDEAD_BEEF_0BAD_F00D, 1'b0, '{1'b0, 64'h0, 1'b0}},
      '{OP_LOOKUP, 44'h123_4567_89AB, 64'h0,                  1'b0, '{1'b0, 64'h0, 1'b0}},
      '{OP_FILL,   44'h555_5555_5555, 64'h5555_5555_5555_5555, 1'b0, '{1'b0, 64'h0, 1'b0}}
   };

   fifo_replacement_lookup_cache_unit #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS),
      .DATA_BITS(DATA_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response side backpressure
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 12);
   end

   // apply one word to the cache model and return what it answers
   function automatic void cache_access(input cache_op_type op,
                                        input logic [KEY_BITS-1:0] key,
                                        input logic [DATA_BITS-1:0] rec,
                                        output cache_result_type res);
      logic found;
      found = 1'b0;
      res = '0;
      if (op == OP_LOOKUP) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (!found && model_valid[i] && model_key[i] == key) begin
               found = 1'b1;
               res.hit = 1'b1;
               res.data = model_rec[i];
            end
         end
      end else begin
         res.evicted = model_valid[model_ptr];
         // keys stay unique: other copies go away without an eviction flag
         for (int i = 0; i < DEPTH; i++) begin
            if (i != model_ptr && model_valid[i] && model_key[i] == key)
               model_valid[i] = 1'b0;
         end
         model_key[model_ptr] = key;
         model_rec[model_ptr] = rec;
         model_valid[model_ptr] = 1'b1;
         model_ptr = (model_ptr == DEPTH - 1) ? 0 : model_ptr + 1;
      end
   endfunction

   function automatic logic key_held(input logic [KEY_BITS-1:0] key);
      logic held;
      held = 1'b0;
      for (int i = 0; i < DEPTH; i++)
         if (model_valid[i] && model_key[i] == key)
            held = 1'b1;
      return held;
   endfunction

   // drive one request word, wait for the handshake, then book its answer
   task automatic send_word(input cache_op_type op, input logic [KEY_BITS-1:0] key,
                            input logic [DATA_BITS-1:0] rec, input logic typed,
                            input cache_result_type want);
      cache_result_type res;
      while (!quiet && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_BITS - KEY_BITS - DATA_BITS){1'b0}}, rec, key};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      cache_access(op, key, rec, res);
      results_due.push_back(typed ? want : res);
      words_sent++;
   endtask

   // response checker
   always @(posedge clock) begin
      cache_result_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            $error("response word with nothing outstanding: data %h user %b",
                   rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            due = results_due.pop_front();
            if (rsp_tuser[0] !== due.hit) begin
               $error("hit: expected %b, got %b", due.hit, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tdata[DATA_BITS-1:0] !== due.data) begin
               $error("data: expected %h, got %h", due.data, rsp_tdata[DATA_BITS-1:0]);
               error_count++;
            end
            if (rsp_tuser[1] !== due.evicted) begin
               $error("evicted: expected %b, got %b", due.evicted, rsp_tuser[1]);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [63:0]          r64;
      logic [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0] rec;
      int                   pick;
      int                   start_count;

      for (int i = 0; i < DEPTH; i++) begin
         model_key[i]   = '0;
         model_rec[i]   = '0;
         model_valid[i] = 1'b0;
      end
      model_ptr = 0;
      for (int i = 0; i < KEY_POOL; i++) begin
         r64 = {$urandom, $urandom};
         key_pool[i] = r64[KEY_BITS-1:0];
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i])
         send_word(directed_rows[i].op, directed_rows[i].key, directed_rows[i].rec,
                   directed_rows[i].typed, directed_rows[i].want);

      // random traffic, mostly over a shared key pool, with lookup-then-fill-on-miss the most common case
      start_count = words_sent;
      while (words_sent - start_count < RANDOM_WORDS) begin
         quiet <= (words_sent - start_count >= 500) && (words_sent - start_count < 750);
         key = key_pool[$urandom_range(KEY_POOL - 1)];
         r64 = {$urandom, $urandom};
         rec = r64;
         pick = $urandom_range(99);
         if (pick < 45) begin
            send_word(OP_LOOKUP, key, {$urandom, $urandom}, 1'b0, '0);
            if (!key_held(key) && $urandom_range(9) != 0)
               send_word(OP_FILL, key, rec, 1'b0, '0);
         end else if (pick < 60) begin
            // fill of a key that may already be held elsewhere
            send_word(OP_FILL, key, rec, 1'b0, '0);
         end else if (pick < 65) begin
            // refill the key sitting under the write pointer
            if (model_valid[model_ptr])
               key = model_key[model_ptr];
            send_word(OP_FILL, key, rec, 1'b0, '0);
         end else if (pick < 80) begin
            send_word(OP_LOOKUP, key, '0, 1'b0, '0);
         end else begin
            r64 = {$urandom, $urandom};
            send_word(cache_op_type'($urandom_range(1)), r64[KEY_BITS-1:0], rec, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;
      quiet <= 1'b0;

      // drain, then give stray words time to show up
      while (results_due.size() != 0)
         @(posedge clock);
      repeat (DEPTH + 64) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
hdl/flc_pkg.sv
hdl/flc_cell.sv
hdl/fifo_replacement_lookup_cache_unit.sv
sim/tb_fifo_replacement_lookup_cache_unit.sv
